@@ rtl/core/cqm_pkg.sv @@
// ----------------------------------------------------------------------------
// cqm_pkg
// Shared types and constants for the circular queue with running maximum.
// ----------------------------------------------------------------------------
package cqm_pkg;

   localparam int CQM_DEPTH = 128;
   localparam int WORD_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int ITEM_W    = 7;

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // operation codes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] RS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] RS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] RS_EMPTY = 2'd2;

   typedef struct packed {
      logic                     kind;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] removed_word;
      logic [STATUS_W-1:0]      status;
      logic [ITEM_W-1:0]        item_count;
      logic signed [WORD_W-1:0] largest_word;
      logic                     is_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENQ_CHK,
      ST_ENQ_CMP,
      ST_DEQ_FIN
   } state_type;

endpackage

@@ rtl/core/cqm_mem.sv @@
// ----------------------------------------------------------------------------
// cqm_mem
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cqm_mem
   import cqm_pkg::*;
#(
   parameter int WIDTH = WORD_W,
   parameter int DEPTH = CQM_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/circular_queue_with_max.sv @@
// ----------------------------------------------------------------------------
// circular_queue_with_max
// Ring-buffer FIFO of signed words (DEPTH-1 usable slots) that reports the
// largest queued word after every enqueue or dequeue.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   req_word                 taken when start && !busy
//  result    rsp_word                 valid for one cycle with rsp_strobe
//
//  Dropped enqueue (full) or dequeue on empty: answered from idle, no busy.
//  Dequeue: ST_DEQ_FIN (one registered read of the data and max RAMs).
//  Enqueue: ST_ENQ_CHK reads the back of the max-candidate list, ST_ENQ_CMP
//  drops it and loops back if smaller (one RAM read and compare per entry),
//  else pushes; ST_ENQ_CHK pushes directly when the list is empty.
//  Result appears the cycle after the word finishes; no stall on that side.
//  Reset empties the queue at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_max
   import cqm_pkg::*;
#(
   parameter int DEPTH = CQM_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW = WORD_W + AW;

   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
      return (i == AW'(DEPTH-1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
      return (i == '0) ? AW'(DEPTH-1) : i - AW'(1);
   endfunction

   state_type                state_ff, state_in;
   logic signed [WORD_W-1:0] value_ff, value_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [AW-1:0]            tail_ff, tail_in;
   logic [AW-1:0]            cnt_ff, cnt_in;
   logic [AW-1:0]            dq_head_ff, dq_head_in;
   logic [AW-1:0]            dq_tail_ff, dq_tail_in;
   logic [AW-1:0]            dq_cnt_ff, dq_cnt_in;
   logic signed [WORD_W-1:0] max_ff, max_in;
   logic [AW-1:0]            front_ff, front_in;
   logic                     pop_front_ff, pop_front_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_type                  rsp_ff, rsp_in;

   // data ring
   logic                     ring_we;
   logic [WORD_W-1:0]        ring_rd;

   // max-candidate list: {word, ring slot}, non-increasing from front to back
   logic                     dq_we;
   logic [AW-1:0]            dq_raddr;
   logic [DW-1:0]            dq_rd;
   logic signed [WORD_W-1:0] dq_rd_word;
   logic [AW-1:0]            dq_rd_slot;
   logic                     do_push;

   cqm_mem #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (tail_ff),
      .wr_data (value_ff),
      .rd_addr (head_ff),
      .rd_data (ring_rd)
   );

   cqm_mem #(.WIDTH(DW), .DEPTH(DEPTH)) u_cand (
      .clock   (clock),
      .wr_en   (dq_we),
      .wr_addr (dq_tail_ff),
      .wr_data ({value_ff, tail_ff}),
      .rd_addr (dq_raddr),
      .rd_data (dq_rd)
   );

   assign dq_rd_word = dq_rd[DW-1 -: WORD_W];
   assign dq_rd_slot = dq_rd[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         cnt_ff        <= '0;
         dq_head_ff    <= '0;
         dq_tail_ff    <= '0;
         dq_cnt_ff     <= '0;
         max_ff        <= WORD_MIN;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         dq_head_ff    <= dq_head_in;
         dq_tail_ff    <= dq_tail_in;
         dq_cnt_ff     <= dq_cnt_in;
         max_ff        <= max_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      value_ff     <= value_in;
      front_ff     <= front_in;
      pop_front_ff <= pop_front_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      dq_head_in    = dq_head_ff;
      dq_tail_in    = dq_tail_ff;
      dq_cnt_in     = dq_cnt_ff;
      max_in        = max_ff;
      front_in      = front_ff;
      pop_front_in  = pop_front_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ring_we       = 1'b0;
      dq_we         = 1'b0;
      dq_raddr      = idx_inc(dq_head_ff);
      do_push       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            value_in     = req_word.value;
            pop_front_in = (front_ff == head_ff);
            if (start) begin
               rsp_in.removed_word = WORD_MIN;
               rsp_in.item_count   = ITEM_W'(cnt_ff);
               rsp_in.largest_word = max_ff;
               rsp_in.is_empty     = (cnt_ff == '0);
               if (req_word.kind == OP_ENQ) begin
                  if (cnt_ff == AW'(DEPTH-1)) begin
                     rsp_in.status = RS_FULL;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = ST_ENQ_CHK;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     rsp_in.status = RS_EMPTY;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     // ring[head] and the next candidate are read this cycle
                     state_in = ST_DEQ_FIN;
                  end
               end
            end
         end

         ST_ENQ_CHK: begin
            dq_raddr = idx_dec(dq_tail_ff);
            if (dq_cnt_ff == '0) begin
               do_push = 1'b1;
            end else begin
               state_in = ST_ENQ_CMP;
            end
         end

         ST_ENQ_CMP: begin
            if (dq_rd_word < value_ff) begin
               // smaller older word can never be the max again
               dq_tail_in = idx_dec(dq_tail_ff);
               dq_cnt_in  = dq_cnt_ff - AW'(1);
               state_in   = ST_ENQ_CHK;
            end else begin
               do_push = 1'b1;
            end
         end

         ST_DEQ_FIN: begin
            head_in = idx_inc(head_ff);
            cnt_in  = cnt_ff - AW'(1);
            if (pop_front_ff) begin
               dq_head_in = idx_inc(dq_head_ff);
               dq_cnt_in  = dq_cnt_ff - AW'(1);
               if (dq_cnt_ff == AW'(1)) begin
                  max_in = WORD_MIN;
               end else begin
                  max_in   = dq_rd_word;
                  front_in = dq_rd_slot;
               end
            end
            rsp_in.removed_word = ring_rd;
            rsp_in.status       = RS_OK;
            rsp_in.item_count   = ITEM_W'(cnt_in);
            rsp_in.largest_word = max_in;
            rsp_in.is_empty     = (cnt_in == '0);
            rsp_strobe_in       = 1'b1;
            state_in            = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_push) begin
         ring_we    = 1'b1;
         dq_we      = 1'b1;
         tail_in    = idx_inc(tail_ff);
         cnt_in     = cnt_ff + AW'(1);
         dq_tail_in = idx_inc(dq_tail_ff);
         dq_cnt_in  = dq_cnt_ff + AW'(1);
         if (dq_cnt_ff == '0) begin
            max_in   = value_ff;
            front_in = tail_ff;
         end
         rsp_in.removed_word = WORD_MIN;
         rsp_in.status       = RS_OK;
         rsp_in.item_count   = ITEM_W'(cnt_in);
         rsp_in.largest_word = max_in;
         rsp_in.is_empty     = 1'b0;
         rsp_strobe_in       = 1'b1;
         state_in            = ST_IDLE;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_queue_with_max: directed enqueue/dequeue
// words at the value extremes, then random fill, drain and mixed traffic with
// random start gaps. A local queue model predicts every result word, and
// the checker compares each one as it is strobed out.
// ----------------------------------------------------------------------------
module testbench;
   import cqm_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   circular_queue_with_max i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   // queue model state
   logic signed [WORD_W-1:0] model_ring [CQM_DEPTH];
   int                       model_head;
   int                       model_tail;

   rsp_type pending_rsp [$];
   int      fault_count;
   bit      no_idle;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic rsp_type apply_queue_op(req_type w);
      rsp_type                  r;
      logic signed [WORD_W-1:0] best;
      int                       i;
      r.removed_word = WORD_MIN;
      r.status       = RS_OK;
      if (w.kind == OP_ENQ) begin
         if ((model_tail + 1) % CQM_DEPTH == model_head) begin
            r.status = RS_FULL;
         end else begin
            model_ring[model_tail] = w.value;
            model_tail = (model_tail + 1) % CQM_DEPTH;
         end
      end else begin
         if (model_head == model_tail) begin
            r.status = RS_EMPTY;
         end else begin
            r.removed_word = model_ring[model_head];
            model_head = (model_head + 1) % CQM_DEPTH;
         end
      end
      r.item_count = ITEM_W'((model_tail + CQM_DEPTH - model_head) % CQM_DEPTH);
      best = WORD_MIN;
      for (i = model_head; i != model_tail; i = (i + 1) % CQM_DEPTH) begin
         if ($signed(model_ring[i]) > $signed(best))
            best = model_ring[i];
      end
      r.largest_word = best;
      r.is_empty     = (model_head == model_tail);
      return r;
   endfunction

   // mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle)
         return 0;
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return $urandom;
      if (roll < 8)
         return WORD_W'($signed($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 3))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return WORD_MIN + 1;
         default: return WORD_MAX - 1;
      endcase
   endfunction

   task automatic send_word(input logic kind, input logic [WORD_W-1:0] value);
      req_type w;
      int      gap;
      w.kind  = kind;
      w.value = value;
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_rsp.push_back(apply_queue_op(w));
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic enq(input logic [WORD_W-1:0] value);
      send_word(OP_ENQ, value);
   endtask

   task automatic deq();
      send_word(OP_DEQ, $urandom);
   endtask

   task automatic test_empty_queue();
      deq();
      deq();
   endtask

   task automatic test_extreme_words();
      enq(WORD_MIN);
      enq('1);
      enq('0);
      enq(WORD_MAX);
      enq(WORD_MAX);
      enq(1);
      repeat (6) deq();
      deq();
   endtask

   // a rising word after a falling run knocks out every earlier candidate
   task automatic test_falling_then_peak();
      no_idle = 1'b1;
      enq(5);
      enq(4);
      enq(3);
      enq(2);
      enq(10);
      repeat (5) deq();
      no_idle = 1'b0;
   endtask

   // runs past full and past empty; indices wrap along the way
   task automatic test_fill_and_drain();
      int n;
      for (n = 0; n < CQM_DEPTH + 2; n++) begin
         no_idle = (n % 40) < 15;
         enq(pick_value());
      end
      for (n = 0; n < CQM_DEPTH + 2; n++) begin
         no_idle = (n % 40) >= 25;
         deq();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_mix();
      int phase;
      int n;
      int len;
      int enq_pct;
      for (phase = 0; phase < 4; phase++) begin
         len     = $urandom_range(30, 45);
         enq_pct = (phase == 0) ? 85 : (phase == 1) ? 50 : (phase == 2) ? 70 : 20;
         no_idle = (phase == 2);
         for (n = 0; n < len; n++) begin
            if ($urandom_range(0, 99) < enq_pct)
               enq(pick_value());
            else
               deq();
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("result word strobed with none outstanding");
            fault_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("removed_word", want.removed_word, rsp_word.removed_word);
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_word.status));
            check_field("item_count", WORD_W'(want.item_count),
                        WORD_W'(rsp_word.item_count));
            check_field("largest_word", want.largest_word, rsp_word.largest_word);
            check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp_word.is_empty));
         end
      end
   end

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      fault_count = 0;
      no_idle     = 1'b0;
      model_head  = 0;
      model_tail  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_word    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extreme_words();
      test_falling_then_peak();
      test_fill_and_drain();
      test_random_mix();

      start <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fault_count == 0 && pending_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
